>>> rtl/nls_pkg.sv
package nls_pkg;

  localparam int DEF_MAX_LIGHTS = 16;
  localparam int DEF_COORD_BITS = 16;

  localparam int MODE_W     = 2;
  localparam int POS_W      = 16;
  localparam int ID_W       = 16;
  localparam int LIMIT_W    = 7;
  localparam int STATUS_W   = 2;
  localparam int SLOT_OUT_W = 6;
  localparam int DIST_OUT_W = 34;

  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ACK   = 2'd3;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/nls_ram.sv
module nls_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/nls_dist.sv
module nls_dist #(
  parameter int CW = 16,
  parameter int SW = 4,
  localparam int DW = 2 * CW + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_vld,
  input  logic [CW-1:0]          lx,
  input  logic [CW-1:0]          ly,
  input  logic [CW-1:0]          lz,
  input  logic [CW-1:0]          qx,
  input  logic [CW-1:0]          qy,
  input  logic [CW-1:0]          qz,
  input  logic [SW-1:0]          in_slot,
  input  logic [nls_pkg::ID_W-1:0] in_id,
  output logic                   out_vld,
  output logic [DW-1:0]          out_dist,
  output logic [SW-1:0]          out_slot,
  output logic [nls_pkg::ID_W-1:0] out_id
);
  import nls_pkg::*;

  function automatic logic [CW-1:0] mag(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic signed [CW:0] d;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    return d[CW] ? CW'(-d) : d[CW-1:0];
  endfunction

  logic              v1, v2;
  logic [CW-1:0]     m_x, m_y, m_z;
  logic [2*CW-1:0]   sq_x, sq_y, sq_z;
  logic [SW-1:0]     slot1, slot2;
  logic [ID_W-1:0]   id1, id2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      v1      <= in_vld;
      v2      <= v1;
      out_vld <= v2;
    end
    m_x      <= mag(lx, qx);
    m_y      <= mag(ly, qy);
    m_z      <= mag(lz, qz);
    slot1    <= in_slot;
    id1      <= in_id;
    sq_x     <= (2*CW)'(m_x) * (2*CW)'(m_x);
    sq_y     <= (2*CW)'(m_y) * (2*CW)'(m_y);
    sq_z     <= (2*CW)'(m_z) * (2*CW)'(m_z);
    slot2    <= slot1;
    id2      <= id1;
    out_dist <= DW'(sq_x) + DW'(sq_y) + DW'(sq_z);
    out_slot <= slot2;
    out_id   <= id2;
  end

endmodule

>>> rtl/nls_sort_cell.sv
module nls_sort_cell #(
  parameter int DW = 34,
  parameter int SW = 4,
  localparam int EW = 1 + DW + SW + nls_pkg::ID_W
) (
  input  logic               clk,
  input  logic               rst,
  input  nls_pkg::cell_ctl_t ctl,
  input  logic [EW-1:0]      ins,
  input  logic [EW-1:0]      right,
  output logic [EW-1:0]      held,
  output logic [EW-1:0]      pass
);
  import nls_pkg::*;

  logic          in_vld, h_vld, less;
  logic [DW-1:0] in_dist, h_dist;
  logic [SW-1:0] in_slot, h_slot;

  assign in_vld  = ins[EW-1];
  assign in_dist = ins[EW-2 -: DW];
  assign in_slot = ins[ID_W +: SW];
  assign h_vld   = held[EW-1];
  assign h_dist  = held[EW-2 -: DW];
  assign h_slot  = held[ID_W +: SW];
  assign less    = !h_vld || (in_dist < h_dist) || ((in_dist == h_dist) && (in_slot < h_slot));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      held[EW-1] <= 1'b0;
      pass[EW-1] <= 1'b0;
    end else if (ctl.shift) begin
      held       <= right;
      pass[EW-1] <= 1'b0;
    end else if (in_vld && less) begin
      held <= ins;
      pass <= held;
    end else if (in_vld) begin
      pass <= ins;
    end else begin
      pass[EW-1] <= 1'b0;
    end
  end

endmodule

>>> rtl/nearest_lights_selector_top.sv
// Nearest lights selector.
// Command port: a transaction is taken on a clock edge with start high and busy low.
// mode add stores (pos_x, pos_y, pos_z, light_id) in the next free slot; clear empties
// the table; query returns up to max_count stored lights, nearest first by squared
// distance, ties to the lower slot. Mode 3 is dropped without a result.
// Results appear one per cycle on the result ports with result_valid high for one
// cycle; last marks the final result of a transaction. The receiver cannot stall.
// Add, clear and an empty query give one result in the cycle after acceptance; busy
// stays low, so a new transaction can be taken every cycle.
// A query with results (N stored lights, K results) runs in three phases:
// the table RAM is read one slot per cycle into a three-stage distance pipeline,
// which feeds a chain of MAX_LIGHTS insertion-sort cells; after the chain settles,
// it shifts one sorted entry per cycle out of its head. busy is high throughout.
// Reset empties the table and returns to idle; table contents are not cleared.
module nearest_lights_selector_top #(
  parameter int MAX_LIGHTS = nls_pkg::DEF_MAX_LIGHTS,
  parameter int COORD_BITS = nls_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [nls_pkg::MODE_W-1:0]        mode,
  input  logic signed [nls_pkg::POS_W-1:0]  pos_x,
  input  logic signed [nls_pkg::POS_W-1:0]  pos_y,
  input  logic signed [nls_pkg::POS_W-1:0]  pos_z,
  input  logic [nls_pkg::ID_W-1:0]          light_id,
  input  logic [nls_pkg::LIMIT_W-1:0]       max_count,
  output logic                              result_valid,
  output logic [nls_pkg::STATUS_W-1:0]      status,
  output logic [nls_pkg::ID_W-1:0]          found_id,
  output logic [nls_pkg::SLOT_OUT_W-1:0]    slot_index,
  output logic [nls_pkg::DIST_OUT_W-1:0]    distance_sq,
  output logic                              last
);
  import nls_pkg::*;

  localparam int CW         = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam int DW         = 2 * CW + 2;
  localparam int SW         = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);
  localparam int RW         = 3 * CW + ID_W;
  localparam int EW         = 1 + DW + SW + ID_W;
  localparam int SETTLE_CYC = MAX_LIGHTS + 6;
  localparam int WAIT_W     = $clog2(SETTLE_CYC + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FEED   = 2'd1;
  localparam logic [1:0] S_SETTLE = 2'd2;
  localparam logic [1:0] S_DRAIN  = 2'd3;

  logic [1:0]         state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   want, want_next;
  logic [CNT_W-1:0]   feed_cnt, feed_cnt_next;
  logic [CNT_W-1:0]   out_cnt, out_cnt_next;
  logic [WAIT_W-1:0]  wait_cnt, wait_cnt_next;
  logic [CW-1:0]      qx, qy, qz;
  logic               accept;
  logic [LIMIT_W-1:0] cnt_ext, want_full;
  logic               ram_we;
  logic [RW-1:0]      ram_rdata;
  logic               rd_vld;
  logic [SW-1:0]      rd_slot;
  logic               d_vld;
  logic [DW-1:0]      d_dist;
  logic [SW-1:0]      d_slot;
  logic [ID_W-1:0]    d_id;
  cell_ctl_t          ctl;
  logic [EW-1:0]      chain_in [MAX_LIGHTS];
  logic [EW-1:0]      chain_held [MAX_LIGHTS];
  logic [EW-1:0]      chain_right [MAX_LIGHTS];
  logic [EW-1:0]      head;

  logic                  result_valid_next, last_next;
  logic [STATUS_W-1:0]   status_next;
  logic [ID_W-1:0]       found_id_next;
  logic [SLOT_OUT_W-1:0] slot_index_next;
  logic [DIST_OUT_W-1:0] distance_sq_next;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign cnt_ext   = LIMIT_W'(count);
  assign want_full = (max_count < cnt_ext) ? max_count : cnt_ext;
  assign ram_we    = accept && (mode == MODE_ADD) && (count < CNT_W'(MAX_LIGHTS));
  assign head      = chain_held[0];

  nls_ram #(.WIDTH(RW), .DEPTH(MAX_LIGHTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[SW-1:0]),
    .wdata ({pos_x[CW-1:0], pos_y[CW-1:0], pos_z[CW-1:0], light_id}),
    .raddr (feed_cnt[SW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_FEED);
    end
    rd_slot <= feed_cnt[SW-1:0];
  end

  nls_dist #(.CW(CW), .SW(SW)) u_dist (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (rd_vld),
    .lx       (ram_rdata[RW-1 -: CW]),
    .ly       (ram_rdata[RW-CW-1 -: CW]),
    .lz       (ram_rdata[ID_W +: CW]),
    .qx       (qx),
    .qy       (qy),
    .qz       (qz),
    .in_slot  (rd_slot),
    .in_id    (ram_rdata[ID_W-1:0]),
    .out_vld  (d_vld),
    .out_dist (d_dist),
    .out_slot (d_slot),
    .out_id   (d_id)
  );

  assign chain_in[0] = {d_vld, d_dist, d_slot, d_id};

  for (genvar i = 0; i < MAX_LIGHTS; i++) begin : g_cell
    if (i < MAX_LIGHTS - 1) begin : g_mid
      assign chain_right[i] = chain_held[i+1];
      nls_sort_cell #(.DW(DW), .SW(SW)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .ins   (chain_in[i]),
        .right (chain_right[i]),
        .held  (chain_held[i]),
        .pass  (chain_in[i+1])
      );
    end else begin : g_end
      assign chain_right[i] = '0;
      nls_sort_cell #(.DW(DW), .SW(SW)) u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctl   (ctl),
        .ins   (chain_in[i]),
        .right (chain_right[i]),
        .held  (chain_held[i]),
        .pass  ()
      );
    end
  end

  always_comb begin
    state_next        = state;
    count_next        = count;
    want_next         = want;
    feed_cnt_next     = feed_cnt;
    out_cnt_next      = out_cnt;
    wait_cnt_next     = wait_cnt;
    ctl               = '0;
    result_valid_next = 1'b0;
    status_next       = ST_OK;
    found_id_next     = '0;
    slot_index_next   = '0;
    distance_sq_next  = '0;
    last_next         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_ADD: begin
              result_valid_next = 1'b1;
              last_next         = 1'b1;
              found_id_next     = light_id;
              if (count < CNT_W'(MAX_LIGHTS)) begin
                slot_index_next = SLOT_OUT_W'(count);
                count_next      = count + 1'b1;
              end else begin
                status_next = ST_FULL;
              end
            end
            MODE_CLEAR: begin
              result_valid_next = 1'b1;
              last_next         = 1'b1;
              status_next       = ST_ACK;
              count_next        = '0;
            end
            MODE_QUERY: begin
              if (want_full == '0) begin
                result_valid_next = 1'b1;
                last_next         = 1'b1;
                status_next       = ST_EMPTY;
              end else begin
                want_next     = CNT_W'(want_full);
                feed_cnt_next = '0;
                ctl.clear     = 1'b1;
                state_next    = S_FEED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FEED: begin
        feed_cnt_next = feed_cnt + 1'b1;
        if (feed_cnt == count - 1'b1) begin
          wait_cnt_next = '0;
          state_next    = S_SETTLE;
        end
      end
      S_SETTLE: begin
        wait_cnt_next = wait_cnt + 1'b1;
        if (wait_cnt == WAIT_W'(SETTLE_CYC - 1)) begin
          out_cnt_next = '0;
          state_next   = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ctl.shift         = 1'b1;
        result_valid_next = 1'b1;
        found_id_next     = head[ID_W-1:0];
        slot_index_next   = SLOT_OUT_W'(head[ID_W +: SW]);
        distance_sq_next  = DIST_OUT_W'(head[EW-2 -: DW]);
        out_cnt_next      = out_cnt + 1'b1;
        if (out_cnt == want - 1'b1) begin
          last_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      result_valid <= result_valid_next;
    end
    want        <= want_next;
    feed_cnt    <= feed_cnt_next;
    out_cnt     <= out_cnt_next;
    wait_cnt    <= wait_cnt_next;
    status      <= status_next;
    found_id    <= found_id_next;
    slot_index  <= slot_index_next;
    distance_sq <= distance_sq_next;
    last        <= last_next;
    if (accept && (mode == MODE_QUERY)) begin
      qx <= pos_x[CW-1:0];
      qy <= pos_y[CW-1:0];
      qz <= pos_z[CW-1:0];
    end
  end

endmodule
